FILE: sv/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the epoch-seconds calendar unit
// Widths of the working registers, calendar constants and the month table.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned REM_W   = 17;
  localparam int unsigned YEAR_W  = 12;

  localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;

  // Reciprocals for exact division by multiply and shift over the value
  // ranges seen at each step.
  localparam logic [EPOCH_W-1:0] RECIP_60    = 32'h8888_8889; // ceil(2^37 / 60)
  localparam int unsigned        SH_60       = 37;
  localparam logic [EPOCH_W-1:0] RECIP_24    = 32'd2796203;   // ceil(2^26 / 24)
  localparam int unsigned        SH_24       = 26;
  localparam logic [EPOCH_W-1:0] RECIP_BLOCK = 32'd91868;     // ceil(2^27 / 1461)
  localparam int unsigned        SH_BLOCK    = 27;

  localparam logic [EPOCH_W-1:0] DAYS_PER_BLOCK = 32'd1461;   // four years
  localparam logic [REM_W-1:0]   DAYS_COMMON    = 17'd365;
  localparam logic [REM_W-1:0]   DAYS_LEAP      = 17'd366;

  // zero-based day of year of the leap day in a leap year
  localparam logic [REM_W-1:0] LEAP_DAY_IDX = 17'd59;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  typedef struct packed {
    logic             ge;
    logic [REM_W-1:0] diff;
  } sub_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:                            len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:         len = 5'd30;
      default:                         len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: sv/esc_sub_unit.sv
// ----------------------------------------------------------------------------
// esc_sub_unit: shared compare and subtract
// Gives a >= b and a - b; drives the block remainder and every walk step.
// ----------------------------------------------------------------------------
module esc_sub_unit
  import esc_pkg::*;
(
  input  logic [REM_W-1:0] a,
  input  logic [REM_W-1:0] b,
  output sub_res_t         res
);

  logic [REM_W:0] wide;

  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~wide[REM_W];
  assign res.diff = wide[REM_W-1:0];

endmodule

FILE: sv/epoch_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: seconds since 1970 to UTC calendar fields
// Sequencer around one shared multiplier and one compare/subtract unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, epoch_seconds) takes one request: an
//   unsigned count of seconds since 1970-01-01 00:00:00 UTC. Output channel
//   (out_valid/out_ready) returns year, zero-based month, day, hour, minute
//   and second. Every year divisible by four is a leap year (2100 included).
//
//   Five steps share one 32x32 multiplier: reciprocal multiplies by 1/60,
//   1/60 and 1/24 give minutes, hours and days, then days split into
//   four-year blocks of 1461 days and the block remainder is formed. A year
//   walk, a leap-day step and a month walk follow, each walk taking one
//   compare/subtract a cycle, and a last step loads the output register.
//   One request is in flight at a time; in_ready is high only while the
//   sequencer is idle, so none is taken before the last result is stored.
//
//   The result sits in an output register, so a new request is taken while
//   a finished result waits for out_ready. If the receiver stalls and the
//   register is still full when the next result is done, the sequencer
//   holds that result until the register frees up.
//   Reset clears the sequencer and out_valid; no request survives reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit
  import esc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [EPOCH_W-1:0]  epoch_seconds,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [YEAR_W-1:0]   year,
  output logic [3:0]          month,
  output logic [4:0]          day,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic [5:0]          second
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DIV_SEC  = 4'd1;
  localparam logic [3:0] ST_DIV_MIN  = 4'd2;
  localparam logic [3:0] ST_DIV_HR   = 4'd3;
  localparam logic [3:0] ST_DIV_BLK  = 4'd4;
  localparam logic [3:0] ST_BLK_REM  = 4'd5;
  localparam logic [3:0] ST_YEAR     = 4'd6;
  localparam logic [3:0] ST_MON_PREP = 4'd7;
  localparam logic [3:0] ST_MONTH    = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0]           state;
  logic [EPOCH_W-1:0]   dq;     // value being divided, then its quotient
  logic [REM_W-1:0]     r;      // day within the block, later day index
  logic [5:0]           blk;    // whole four-year blocks
  logic [5:0]           sec_q;
  logic [5:0]           min_q;
  logic [4:0]           hr_q;
  logic [YEAR_W-1:0]    yr_q;
  logic [3:0]           mon_q;

  logic                 leap;
  logic [EPOCH_W-1:0]   mul_a;
  logic [EPOCH_W-1:0]   mul_b;
  logic [2*EPOCH_W-1:0] mul_p;
  logic [26:0]          quot60;
  logic [15:0]          quot24;
  logic [5:0]           quot_blk;
  logic [REM_W-1:0]     op_a;
  logic [REM_W-1:0]     op_b;
  sub_res_t             res;
  logic                 out_free;

  assign leap = (yr_q[1:0] == 2'b00);

  // Shared multiplier: reciprocal divides, then blocks times 1461 days.
  always_comb begin
    mul_a = (state == ST_BLK_REM) ? {{(EPOCH_W-6){1'b0}}, blk} : dq;
    case (state)
      ST_DIV_SEC, ST_DIV_MIN: mul_b = RECIP_60;
      ST_DIV_HR:              mul_b = RECIP_24;
      ST_DIV_BLK:             mul_b = RECIP_BLOCK;
      ST_BLK_REM:             mul_b = DAYS_PER_BLOCK;
      default:                mul_b = '0;
    endcase
  end

  assign mul_p    = {{EPOCH_W{1'b0}}, mul_a} * {{EPOCH_W{1'b0}}, mul_b};
  assign quot60   = mul_p[SH_60 +: 27];
  assign quot24   = mul_p[SH_24 +: 16];
  assign quot_blk = mul_p[SH_BLOCK +: 6];

  always_comb begin
    op_a = (state == ST_BLK_REM) ? dq[REM_W-1:0] : r;
    case (state)
      ST_BLK_REM: op_b = mul_p[REM_W-1:0];
      ST_YEAR:    op_b = leap ? DAYS_LEAP : DAYS_COMMON;
      ST_MONTH:   op_b = {{(REM_W-5){1'b0}}, month_len(mon_q)};
      default:    op_b = '0;
    endcase
  end

  esc_sub_unit u_sub (
    .a   (op_a),
    .b   (op_b),
    .res (res)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Set on a finished result, drop once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            dq    <= epoch_seconds;
            state <= ST_DIV_SEC;
          end
        end
        ST_DIV_SEC: begin
          // remainder mod 64 is exact: -60 == 4 (mod 64)
          sec_q <= dq[5:0] + {quot60[3:0], 2'b00};
          dq    <= {5'b0, quot60};
          state <= ST_DIV_MIN;
        end
        ST_DIV_MIN: begin
          min_q <= dq[5:0] + {quot60[3:0], 2'b00};
          dq    <= {5'b0, quot60};
          state <= ST_DIV_HR;
        end
        ST_DIV_HR: begin
          // -24 == 8 (mod 32)
          hr_q  <= dq[4:0] + {quot24[1:0], 3'b000};
          dq    <= {16'b0, quot24};
          state <= ST_DIV_BLK;
        end
        ST_DIV_BLK: begin
          blk   <= quot_blk;
          yr_q  <= BASE_YEAR + {4'b0, quot_blk, 2'b00};
          state <= ST_BLK_REM;
        end
        ST_BLK_REM: begin
          r     <= res.diff;
          state <= ST_YEAR;
        end
        ST_YEAR: begin
          if (res.ge) begin
            r    <= res.diff;
            yr_q <= yr_q + 12'd1;
          end else begin
            state <= ST_MON_PREP;
          end
        end
        ST_MON_PREP: begin
          if (leap && r == LEAP_DAY_IDX) begin
            mon_q <= MONTH_FEB;
            r     <= 17'd28;
            state <= ST_DONE;
          end else begin
            mon_q <= MONTH_JAN;
            // drop the leap day so the common-year table applies
            if (leap && r > LEAP_DAY_IDX) begin
              r <= r - 17'd1;
            end
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (mon_q != MONTH_DEC && res.ge) begin
            r     <= res.diff;
            mon_q <= mon_q + 4'd1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            year   <= yr_q;
            month  <= mon_q;
            day    <= r[4:0] + 5'd1;
            hour   <= hr_q;
            minute <= min_q;
            second <= sec_q;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker: port-level checks for the epoch-seconds calendar unit
// Watches handshakes and result ranges; bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker
  import esc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [YEAR_W-1:0]  year,
  input logic [3:0]         month,
  input logic [4:0]         day,
  input logic [4:0]         hour,
  input logic [5:0]         minute,
  input logic [5:0]         second
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month) &&
      $stable(day) && $stable(hour) && $stable(minute) && $stable(second))
    else $error("result changed while stalled");

  // Taking a request makes the unit busy: in_ready drops.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month <= MONTH_DEC && day >= 5'd1 &&
      year >= BASE_YEAR && year <= 12'd2106)
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .year      (year),
  .month     (month),
  .day       (day),
  .hour      (hour),
  .minute    (minute),
  .second    (second)
);

FILE: tb/epoch_seconds_to_calendar_unit_tb.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit_tb: self-checking bench for the calendar unit
// Feeds epoch counts through the valid/ready input, predicts each UTC
// breakdown in a scoreboard class and compares every returned field. The
// run covers calendar corners, skewed idling on both sides, a long output
// stall that backs up the input, and a full-rate stream at the end.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit_tb;
  import esc_pkg::*;

  localparam int unsigned SECS_PER_DAY     = 86400;
  localparam int unsigned SECS_PER_BLOCK   = 1461 * SECS_PER_DAY;
  localparam int unsigned HOURS_COMMON_YR  = 365 * 24;
  localparam int unsigned HOURS_PER_LEAPYR = 366 * 24;
  localparam int unsigned LEAP_DAY_OF_YEAR = 60;     // one-based day of Feb 29
  localparam int unsigned ITEMS_PER_PHASE  = 540;
  localparam int unsigned PRESSURE_ITEMS   = 20;
  localparam int unsigned STALL_CYCLES     = 600;    // long output hold-off
  localparam int unsigned SETTLE_CYCLES    = 150;    // above worst-case latency
  localparam int unsigned WATCHDOG_LIMIT   = 4000;

  typedef enum logic [2:0] {
    PH_DIRECTED,
    PH_RECV_SLOW,
    PH_SEND_SLOW,
    PH_PRESSURE,
    PH_FULL_RATE
  } phase_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } cal_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predict the breakdown of each accepted request and hold it
  // until the matching result comes back, oldest first.
  // --------------------------------------------------------------------------
  class calendar_board;
    cal_t        due_dates[$];
    int unsigned failures;
    int unsigned checked;

    function cal_t to_calendar(logic [EPOCH_W-1:0] secs);
      int unsigned rest;
      int unsigned yr;
      int unsigned yr_hours;
      int unsigned doy;
      int unsigned mlen;
      logic [3:0]  mon;
      logic        leap;
      cal_t        c;
      c.second = 6'(secs % 60);
      rest     = secs / 60;
      c.minute = 6'(rest % 60);
      rest     = rest / 60;                 // whole hours since the epoch
      c.hour   = 5'(rest % 24);
      // jump whole four-year blocks, then walk the years inside the block
      yr   = 1970 + 4 * (rest / (HOURS_PER_LEAPYR + 3 * HOURS_COMMON_YR));
      rest = rest % (HOURS_PER_LEAPYR + 3 * HOURS_COMMON_YR);
      yr_hours = (yr % 4 == 0) ? HOURS_PER_LEAPYR : HOURS_COMMON_YR;
      while (rest >= yr_hours) begin
        rest     -= yr_hours;
        yr       += 1;
        yr_hours  = (yr % 4 == 0) ? HOURS_PER_LEAPYR : HOURS_COMMON_YR;
      end
      doy  = rest / 24 + 1;
      leap = (yr % 4 == 0);
      mon  = MONTH_JAN;
      if (leap && doy == LEAP_DAY_OF_YEAR) begin
        mon = MONTH_FEB;
        doy = 29;
      end else begin
        // past the leap day, fold back onto common-year month lengths
        if (leap && doy > LEAP_DAY_OF_YEAR) doy -= 1;
        forever begin
          case (mon)
            4'd1:                    mlen = 28;
            4'd3, 4'd5, 4'd8, 4'd10: mlen = 30;
            default:                 mlen = 31;
          endcase
          if (mon == MONTH_DEC || doy <= mlen) break;
          doy -= mlen;
          mon  = mon + 4'd1;
        end
      end
      c.year  = 12'(yr);
      c.month = mon;
      c.day   = 5'(doy);
      return c;
    endfunction

    function void note_request(logic [EPOCH_W-1:0] secs);
      due_dates.push_back(to_calendar(secs));
    endfunction

    function void check_result(cal_t got);
      cal_t exp;
      if (due_dates.size() == 0) begin
        $error("result with no request pending: %0d-%0d-%0d %0d:%0d:%0d",
               got.year, got.month, got.day, got.hour, got.minute, got.second);
        failures++;
        return;
      end
      exp = due_dates.pop_front();
      checked++;
      if (got.year != exp.year) begin
        $error("year: expected %0d, got %0d", exp.year, got.year);
        failures++;
      end
      if (got.month != exp.month) begin
        $error("month: expected %0d, got %0d", exp.month, got.month);
        failures++;
      end
      if (got.day != exp.day) begin
        $error("day: expected %0d, got %0d", exp.day, got.day);
        failures++;
      end
      if (got.hour != exp.hour) begin
        $error("hour: expected %0d, got %0d", exp.hour, got.hour);
        failures++;
      end
      if (got.minute != exp.minute) begin
        $error("minute: expected %0d, got %0d", exp.minute, got.minute);
        failures++;
      end
      if (got.second != exp.second) begin
        $error("second: expected %0d, got %0d", exp.second, got.second);
        failures++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [EPOCH_W-1:0] epoch_seconds = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [YEAR_W-1:0]  year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;

  phase_t        phase = PH_DIRECTED;
  calendar_board board = new();
  int unsigned   quiet_cycles = 0;
  int unsigned   stall_left = 0;
  bit            stall_done = 1'b0;

  epoch_seconds_to_calendar_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .epoch_seconds (epoch_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Observe both handshakes at the edge; everything sampled here is the
  // value from before the edge, since all drivers use nonblocking updates.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_request(epoch_seconds);
    if (!rst && out_valid && out_ready)
      board.check_result('{year, month, day, hour, minute, second});
  end

  // Receiver: random back-pressure per phase; on entering the pressure
  // phase hold out_ready low for a long stretch so the unit backs up.
  always @(posedge clk) begin
    if (phase == PH_PRESSURE && !stall_done) begin
      stall_left = STALL_CYCLES;
      stall_done = 1'b1;
    end
    if (stall_left != 0) begin
      stall_left -= 1;
      out_ready  <= 1'b0;
    end else begin
      case (phase)
        PH_DIRECTED:  out_ready <= ($urandom_range(0, 99) >= 10);
        PH_RECV_SLOW: out_ready <= ($urandom_range(0, 99) >= 79);
        PH_SEND_SLOW: out_ready <= ($urandom_range(0, 99) >= 26);
        default:      out_ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request; idle first at the phase's rate, then hold valid and
  // payload until the edge that accepts it. Valid stays high on return so a
  // back-to-back request never toggles it within one step.
  task automatic send_request(input logic [EPOCH_W-1:0] secs);
    int unsigned idle_pct;
    case (phase)
      PH_DIRECTED:  idle_pct = 10;
      PH_RECV_SLOW: idle_pct = 26;
      PH_SEND_SLOW: idle_pct = 79;
      default:      idle_pct = 0;
    endcase
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random epoch: half uniform over the full range, the rest aimed at
  // midnight edges and at year and leap-day edges inside four-year blocks.
  function automatic logic [EPOCH_W-1:0] pick_epoch();
    longint unsigned v;
    longint unsigned base;
    int unsigned     day_off;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      2: begin
        base = $urandom_range(0, 49710);
        v    = base * SECS_PER_DAY;
        v   += $urandom_range(0, 1) ? SECS_PER_DAY - 1 : $urandom_range(0, 3);
      end
      default: begin
        case ($urandom_range(0, 5))
          0:       day_off = 0;
          1:       day_off = 364 + $urandom_range(0, 1);
          2:       day_off = 729 + $urandom_range(0, 1);
          3:       day_off = 788 + $urandom_range(0, 2);   // around Feb 29
          4:       day_off = 1095 + $urandom_range(0, 1);
          default: day_off = 1460;
        endcase
        base = $urandom_range(0, 34);
        v    = base * SECS_PER_BLOCK + longint'(day_off) * SECS_PER_DAY;
        v   += $urandom_range(0, SECS_PER_DAY - 1);
      end
    endcase
    if (v > 64'hFFFF_FFFF) v = $urandom;
    return v[EPOCH_W-1:0];
  endfunction

  initial begin
    logic [EPOCH_W-1:0] corners[$];
    corners = '{
      32'd0,                // epoch start
      32'hFFFF_FFFF,        // last representable second, February 2106
      32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd68169599,         // 1972-02-28 23:59:59
      32'd68169600,         // first leap day after the epoch
      32'd68256000,         // 1972-03-01
      32'd94694399,         // last second of a leap year
      32'd94694400,         // 1973-01-01
      32'd946684799, 32'd946684800,
      32'd951782400,        // 2000-02-29
      32'd951868800,        // 2000-03-01
      32'd4107542399,       // 2100-02-28 23:59:59
      32'd4107542400,       // 2100 counts as leap: Feb 29 exists
      32'd4134067199,       // 2100-12-31 23:59:59 (366-day year)
      32'd4134067200,       // 2101-01-01
      32'hAAAA_AAAA, 32'h5555_5555
    };

    // Hold reset from time zero, then release it at an edge.
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corners[i]) send_request(corners[i]);

    phase <= PH_RECV_SLOW;
    repeat (ITEMS_PER_PHASE) send_request(pick_epoch());

    phase <= PH_SEND_SLOW;
    repeat (ITEMS_PER_PHASE) send_request(pick_epoch());

    // Keep offering while the receiver stalls; once a result waits behind a full output register, input is refused.
    phase <= PH_PRESSURE;
    repeat (PRESSURE_ITEMS) send_request(pick_epoch());

    phase <= PH_FULL_RATE;
    repeat (ITEMS_PER_PHASE) send_request(pick_epoch());
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for anything spurious.
    while (board.due_dates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d conversions: calendar corners incl. 2100 leap day, skewed idling,",
             board.checked);
    $display("a %0d-cycle output stall with input backed up, and a full-rate stream.",
             STALL_CYCLES);
    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
